// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ----- hw/rtl/dlfm_pkg.sv -----
// Constants, codes and control structs of the dense layer MAC block.
// Depends on nothing; the interfaces, sequencer, MAC unit, top level, checker and testbench import it.
package dlfm_pkg;

	// Sizing of the layer and the fixed-point format.
	localparam int MAX_INPUTS = 64;
	localparam int MAX_NODES  = 16;
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = DATA_WIDTH - 4;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int ACC_W      = 40;

	// Widths fixed by the register map and the result fields.
	localparam int NUM_INPUTS_W = 7;
	localparam int NUM_NODES_W  = 5;
	localparam int CFG_DATA_W   = 7;
	localparam int CFG_IDX_W    = 1;
	localparam int NODE_INDEX_W = 4;

	// Widths derived from the sizing.
	localparam int IN_CNT_W   = $clog2(MAX_INPUTS + 1);
	localparam int EC_W       = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NODE_CNT_W = $clog2(MAX_NODES + 1);
	localparam int WDEPTH     = MAX_INPUTS * MAX_NODES;
	localparam int WADDR_W    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

	// Item function codes.
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_INPUTS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_NODES  = CFG_IDX_W'(1);

	// Sequencer to MAC unit control.
	typedef struct packed {
		logic                         issue;
		logic [NODE_W-1:0]            node;
		logic                         final_row;
		logic signed [DATA_WIDTH-1:0] x;
		logic                         clear_all;
		logic                         emit_load;
		logic                         emit_last;
	} mac_ctrl_t;

	// Sequencer to parameter store write port.
	typedef struct packed {
		logic                  w_we;
		logic                  b_we;
		logic [WADDR_W-1:0]    w_addr;
		logic [NODE_W-1:0]     b_addr;
		logic [DATA_WIDTH-1:0] data;
	} store_wr_t;

endpackage

// ----- hw/rtl/dlfm_ifs.sv -----
// Valid/ready channel interfaces for the input items and the result items.
// Depends on dlfm_pkg for the payload widths.
interface dlfm_in_if;
	import dlfm_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         func;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

interface dlfm_out_if;
	import dlfm_pkg::*;

	logic                           valid;
	logic                           ready;
	logic        [NODE_INDEX_W-1:0] node_index;
	logic signed [ACC_W-1:0]        sum;
	logic                           last;

	modport source (output valid, output node_index, output sum, output last, input ready);
	modport sink (input valid, input node_index, input sum, input last, output ready);
endinterface

// ----- hw/rtl/dlfm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dlfm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/dlfm_mac.sv -----
// Shared multiply-accumulate unit: product stage, accumulator file and result register.
// Depends on dlfm_pkg; weight and bias words come from the parameter stores.
module dlfm_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  dlfm_pkg::mac_ctrl_t                    ctrl,
	input  logic signed [dlfm_pkg::DATA_WIDTH-1:0] w_rdata,
	input  logic signed [dlfm_pkg::DATA_WIDTH-1:0] b_rdata,
	output logic                                   busy,
	output logic [dlfm_pkg::NODE_INDEX_W-1:0]      node_index,
	output logic signed [dlfm_pkg::ACC_W-1:0]      sum,
	output logic                                   last
);
	import dlfm_pkg::*;

	logic                         valid_s1;
	logic                         final_s1;
	logic [NODE_W-1:0]            node_s1;
	logic signed [DATA_WIDTH-1:0] x_s1;
	logic                         valid_s2;
	logic                         final_s2;
	logic [NODE_W-1:0]            node_s2;
	logic signed [PROD_W-1:0]     prod_s2;
	logic signed [DATA_WIDTH-1:0] bias_s2;
	logic signed [ACC_W-1:0]      acc_q [MAX_NODES];
	logic signed [ACC_W-1:0]      bias_term;
	logic signed [ACC_W-1:0]      acc_next;
	logic [NODE_INDEX_W-1:0]      node_index_q;
	logic signed [ACC_W-1:0]      sum_q;
	logic                         last_q;

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.issue;
			valid_s2 <= valid_s1;
		end
	end

	// Stage payloads: the weight read is in flight in stage one, the product in stage two.
	always_ff @(posedge clk) begin
		node_s1  <= ctrl.node;
		final_s1 <= ctrl.final_row;
		x_s1     <= ctrl.x;
		node_s2  <= node_s1;
		final_s2 <= final_s1;
		prod_s2  <= x_s1 * w_rdata;
		bias_s2  <= b_rdata;
	end

	// On the last element of a row the bias, aligned to the product format, joins the sum.
	always_comb begin
		bias_term = final_s2 ? (ACC_W'(bias_s2) <<< FRAC_BITS) : '0;
		acc_next  = acc_q[node_s2] + ACC_W'(prod_s2) + bias_term;
	end

	// Accumulator file: one node per cycle, cleared as each sum is handed out and all at once on a register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				acc_q[i] <= '0;
			end
		end else if (ctrl.clear_all) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			if (valid_s2) begin
				acc_q[node_s2] <= acc_next;
			end
			if (ctrl.emit_load) begin
				acc_q[ctrl.node] <= '0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (ctrl.emit_load) begin
			sum_q        <= acc_q[ctrl.node];
			node_index_q <= NODE_INDEX_W'(ctrl.node);
			last_q       <= ctrl.emit_last;
		end
	end

	assign busy       = valid_s1 | valid_s2;
	assign node_index = node_index_q;
	assign sum        = sum_q;
	assign last       = last_q;

endmodule

// ----- hw/rtl/dlfm_seq.sv -----
// Sequencer: registers, load pointers, element counter and the node loop.
// Depends on dlfm_pkg; drives the parameter stores and the MAC unit.
module dlfm_seq (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_func,
	input  logic [dlfm_pkg::DATA_WIDTH-1:0]       in_value,
	output logic                                  in_ready,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	input  logic                                  cfg_we,
	input  logic [dlfm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dlfm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  mac_busy,
	output dlfm_pkg::mac_ctrl_t                   mac_ctrl,
	output dlfm_pkg::store_wr_t                   store_wr,
	output logic [dlfm_pkg::WADDR_W-1:0]          w_raddr
);
	import dlfm_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_MAC, S_DRAIN, S_EMIT} state_t;

	state_t                       state_q;
	logic [NUM_INPUTS_W-1:0]      num_inputs_q;
	logic [NUM_NODES_W-1:0]       num_nodes_q;
	logic [IN_CNT_W-1:0]          ni_eff;
	logic [NODE_CNT_W-1:0]        nn_eff;
	logic [EC_W-1:0]              ec_q;
	logic [IN_CNT_W-1:0]          lwp_q;
	logic [IN_CNT_W-1:0]          lwp_m1;
	logic [NODE_W-1:0]            lnp_q;
	logic [NODE_W-1:0]            node_q;
	logic                         final_q;
	logic [DATA_WIDTH-1:0]        x_q;
	logic                         out_valid_q;
	logic                         accept;
	logic                         last_node;
	logic                         last_load_node;
	logic                         emit_load;

	function automatic logic [WADDR_W-1:0] wt_addr(input logic [NODE_W-1:0] n,
			input logic [EC_W-1:0] c);
		wt_addr = WADDR_W'(int'(n) * MAX_INPUTS + int'(c));
	endfunction

	// Register values out of range are clamped to the supported span.
	always_comb begin
		if (num_inputs_q == '0) begin
			ni_eff = IN_CNT_W'(1);
		end else if (int'(num_inputs_q) > MAX_INPUTS) begin
			ni_eff = IN_CNT_W'(MAX_INPUTS);
		end else begin
			ni_eff = IN_CNT_W'(num_inputs_q);
		end
		if (num_nodes_q == '0) begin
			nn_eff = NODE_CNT_W'(1);
		end else if (int'(num_nodes_q) > MAX_NODES) begin
			nn_eff = NODE_CNT_W'(MAX_NODES);
		end else begin
			nn_eff = NODE_CNT_W'(num_nodes_q);
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign accept         = in_valid && in_ready;
	assign last_node      = (NODE_CNT_W'(node_q) + NODE_CNT_W'(1)) == nn_eff;
	assign last_load_node = (NODE_CNT_W'(lnp_q) + NODE_CNT_W'(1)) == nn_eff;
	assign emit_load      = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	assign out_valid      = out_valid_q;
	assign lwp_m1         = lwp_q - IN_CNT_W'(1);

	// Parameter store writes: word zero of a node is its bias, the rest its weights.
	always_comb begin
		store_wr.data   = in_value;
		store_wr.b_we   = accept && (in_func == FUNC_LOAD) && (lwp_q == '0);
		store_wr.w_we   = accept && (in_func == FUNC_LOAD) && (lwp_q != '0);
		store_wr.b_addr = lnp_q;
		store_wr.w_addr = wt_addr(lnp_q, lwp_m1[EC_W-1:0]);
	end

	// MAC unit control and the weight read address.
	always_comb begin
		mac_ctrl.issue     = (state_q == S_MAC);
		mac_ctrl.node      = node_q;
		mac_ctrl.final_row = final_q;
		mac_ctrl.x         = x_q;
		mac_ctrl.clear_all = cfg_we;
		mac_ctrl.emit_load = emit_load;
		mac_ctrl.emit_last = last_node;
		w_raddr            = wt_addr(node_q, ec_q);
	end

	// State, counters and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			num_inputs_q <= NUM_INPUTS_W'(1);
			num_nodes_q  <= NUM_NODES_W'(1);
			ec_q         <= '0;
			lwp_q        <= '0;
			lnp_q        <= '0;
			node_q       <= '0;
			final_q      <= 1'b0;
			x_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// The result register empties when taken and refills during emission.
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				// A register write abandons any partial row and restarts the load sequence.
				unique case (cfg_index)
					CFG_NUM_INPUTS: num_inputs_q <= cfg_data[NUM_INPUTS_W-1:0];
					CFG_NUM_NODES:  num_nodes_q  <= cfg_data[NUM_NODES_W-1:0];
				endcase
				ec_q  <= '0;
				lwp_q <= '0;
				lnp_q <= '0;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept) begin
							if (in_func == FUNC_LOAD) begin
								if (lwp_q == ni_eff) begin
									lwp_q <= '0;
									lnp_q <= last_load_node ? '0 : lnp_q + NODE_W'(1);
								end else begin
									lwp_q <= lwp_q + IN_CNT_W'(1);
								end
							end else begin
								x_q     <= in_value;
								final_q <= (IN_CNT_W'(ec_q) + IN_CNT_W'(1)) == ni_eff;
								node_q  <= '0;
								state_q <= S_MAC;
							end
						end
					end
					S_MAC: begin
						if (last_node) begin
							state_q <= S_DRAIN;
						end else begin
							node_q <= node_q + NODE_W'(1);
						end
					end
					S_DRAIN: begin
						if (!mac_busy) begin
							node_q <= '0;
							if (final_q) begin
								ec_q    <= '0;
								state_q <= S_EMIT;
							end else begin
								ec_q    <= ec_q + EC_W'(1);
								state_q <= S_IDLE;
							end
						end
					end
					S_EMIT: begin
						if (emit_load) begin
							if (last_node) begin
								state_q <= S_IDLE;
							end else begin
								node_q <= node_q + NODE_W'(1);
							end
						end
					end
				endcase
			end
		end
	end

endmodule

// ----- hw/rtl/dense_layer_forward_mac_unit.sv -----
// Top level of the fully connected layer multiply-accumulate block.
// Depends on dlfm_pkg, dlfm_ifs, dlfm_ram, dlfm_mac and dlfm_seq.
//
// Computes z[n] = b[n] + sum over c of x[c]*W[c][n] in signed Q4.12 inputs with
// 40-bit Q16.24 sums. A load item (func 0) writes the next parameter word, for each
// node its bias and then its weights, and leaves the block free for the next item.
// A sample item (func 1) holds off the next item until it is through: the node loop
// issues one weight read per cycle through the single read port of the weight
// memory into the one shared multiplier, followed by the two pipeline stages and
// the drain state. After the last element of a row the block hands out one sum
// per node, one a cycle while the output is taken, and marks the final one with
// last; the next item is taken as soon as the final sum sits in the output register.
// Writing num_inputs or num_nodes clears the accumulators, the element count and
// the load position. Parameter stores come up undefined and need no clearing pass.
module dense_layer_forward_mac_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	dlfm_in_if.sink                         in_ch,
	dlfm_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [dlfm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dlfm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dlfm_pkg::*;

	mac_ctrl_t             mac_ctrl;
	store_wr_t             store_wr;
	logic [WADDR_W-1:0]    w_raddr;
	logic [DATA_WIDTH-1:0] w_rdata;
	logic [DATA_WIDTH-1:0] b_rdata;
	logic                  mac_busy;

	// Sequencer.
	dlfm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_func   (in_ch.func),
		.in_value  (in_ch.value),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mac_busy  (mac_busy),
		.mac_ctrl  (mac_ctrl),
		.store_wr  (store_wr),
		.w_raddr   (w_raddr)
	);

	// Weight store, one row of MAX_INPUTS words per node.
	dlfm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (WDEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (store_wr.w_we),
		.waddr (store_wr.w_addr),
		.wdata (store_wr.data),
		.re    (mac_ctrl.issue),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// Bias store, one word per node.
	dlfm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_NODES)
	) u_bias_ram (
		.clk   (clk),
		.we    (store_wr.b_we),
		.waddr (store_wr.b_addr),
		.wdata (store_wr.data),
		.re    (mac_ctrl.issue),
		.raddr (mac_ctrl.node),
		.rdata (b_rdata)
	);

	// Shared multiply-accumulate unit and result register.
	dlfm_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (mac_ctrl),
		.w_rdata    (w_rdata),
		.b_rdata    (b_rdata),
		.busy       (mac_busy),
		.node_index (out_ch.node_index),
		.sum        (out_ch.sum),
		.last       (out_ch.last)
	);

endmodule

// ----- hw/rtl/dlfm_checker.sv -----
// Port-level checks of the dense layer MAC block, bound to its top level.
// Depends on dlfm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dlfm_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   in_func,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic [dlfm_pkg::NODE_INDEX_W-1:0]      out_node_index,
	input logic signed [dlfm_pkg::ACC_W-1:0]      out_sum,
	input logic                                   out_last
);
	import dlfm_pkg::*;

	// A stalled result holds its payload.
	`ASSERT_NEXT_CYCLE(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_sum) && $stable(out_node_index) && $stable(out_last))

	// A sample item occupies the shared unit, so the block is busy the cycle after.
	`ASSERT_NEXT_CYCLE(a_sample_busy, clk, arst_n, in_valid && in_ready && (in_func == FUNC_SAMPLE), !in_ready)

	// While a row's sums are going out, no new item is taken until the final one is loaded.
	`ASSERT_SAME_CYCLE(a_emit_blocks, clk, arst_n, out_valid && !out_last, !in_ready)

	// Sums of one row follow each other without a gap when taken.
	`ASSERT_NEXT_CYCLE(a_emit_next, clk, arst_n, out_valid && out_ready && !out_last, out_valid)

endmodule

bind dense_layer_forward_mac_unit dlfm_checker u_dlfm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.in_func        (in_ch.func),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.out_node_index (out_ch.node_index),
	.out_sum        (out_ch.sum),
	.out_last       (out_ch.last)
);

// ----- test/tb_dense_layer_forward_mac_unit.sv -----
// Self-checking testbench for the dense layer multiply-accumulate block.
// Drives load and sample items under random bursts and output stalls, and checks every sum.
// Depends on dlfm_pkg, dlfm_ifs and the top level dense_layer_forward_mac_unit.
module tb_dense_layer_forward_mac_unit;
	import dlfm_pkg::*;

	typedef struct packed {
		logic                  func;
		logic [DATA_WIDTH-1:0] value;
	} layer_item_t;

	typedef struct {
		logic [NODE_INDEX_W-1:0] node_index;
		logic [ACC_W-1:0]        sum;
		logic                    last;
	} node_sum_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dlfm_in_if  in_ch ();
	dlfm_out_if out_ch ();

	dense_layer_forward_mac_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Items waiting to be driven and sums waiting to be seen.
	layer_item_t pending_items[$];
	node_sum_t   expected_sums[$];
	int          failure_count;
	int          items_queued;

	// Own copy of the layer state, kept in step with the block.
	logic signed [DATA_WIDTH-1:0] weight_mem [MAX_INPUTS*MAX_NODES];
	logic signed [DATA_WIDTH-1:0] bias_mem [MAX_NODES];
	logic        [ACC_W-1:0]      node_acc [MAX_NODES];
	int                           elem_idx;
	int                           load_node;
	int                           load_word;
	logic [NUM_INPUTS_W-1:0]      reg_inputs;
	logic [NUM_NODES_W-1:0]       reg_nodes;

	// Sender burst state and receiver stall state.
	int burst_left;
	int gap_left;
	int stall_mode;
	int stall_left;
	int stall_tick;

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Effective layer sizes after the register values are clamped.
	function automatic int eff_inputs();
		if (reg_inputs == 0) return 1;
		if (reg_inputs > MAX_INPUTS) return MAX_INPUTS;
		return int'(reg_inputs);
	endfunction

	function automatic int eff_nodes();
		if (reg_nodes == 0) return 1;
		if (reg_nodes > MAX_NODES) return MAX_NODES;
		return int'(reg_nodes);
	endfunction

	// A register write drops any partial row and restarts the load order.
	task automatic restart_layer();
		for (int n = 0; n < MAX_NODES; n++) node_acc[n] = '0;
		elem_idx  = 0;
		load_node = 0;
		load_word = 0;
	endtask

	// Applies one accepted item to the layer state and queues the sums it completes.
	task automatic layer_step(input logic func, input logic [DATA_WIDTH-1:0] value);
		int                           ni;
		int                           nn;
		logic signed [DATA_WIDTH-1:0] x_el;
		logic signed [DATA_WIDTH-1:0] w_el;
		logic signed [ACC_W-1:0]      prod;
		logic signed [ACC_W-1:0]      bias_ext;
		node_sum_t                    res;
		ni = eff_inputs();
		nn = eff_nodes();
		if (load_node >= nn) load_node = 0;
		if (load_word > ni) load_word = 0;
		if (elem_idx >= ni) elem_idx = 0;
		if (func == FUNC_LOAD) begin
			if (load_word == 0)
				bias_mem[load_node] = value;
			else
				weight_mem[load_node*MAX_INPUTS + load_word - 1] = value;
			load_word++;
			if (load_word > ni) begin
				load_word = 0;
				load_node++;
				if (load_node >= nn) load_node = 0;
			end
		end else begin
			x_el = value;
			for (int n = 0; n < nn; n++) begin
				w_el = weight_mem[n*MAX_INPUTS + elem_idx];
				prod = x_el * w_el;
				node_acc[n] = node_acc[n] + prod;
			end
			if (elem_idx + 1 < ni) begin
				elem_idx++;
			end else begin
				for (int n = 0; n < nn; n++) begin
					bias_ext = bias_mem[n];
					bias_ext = bias_ext <<< FRAC_BITS;
					res.node_index = NODE_INDEX_W'(n);
					res.sum        = node_acc[n] + bias_ext;
					res.last       = (n + 1 == nn);
					expected_sums.push_back(res);
					node_acc[n] = '0;
				end
				elem_idx = 0;
			end
		end
	endtask

	task automatic note_failure(input string msg);
		failure_count++;
		if (failure_count <= 10) $display("%s", msg);
	endtask

	// Values lean towards the extremes of Q4.12 and the values around zero.
	function automatic logic [DATA_WIDTH-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return DATA_WIDTH'($urandom);
		endcase
	endfunction

	task automatic queue_item(input logic func, input logic [DATA_WIDTH-1:0] value);
		layer_item_t it;
		it.func  = func;
		it.value = value;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// Register write; only called while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_NUM_INPUTS)
			reg_inputs = data[NUM_INPUTS_W-1:0];
		else
			reg_nodes = data[NUM_NODES_W-1:0];
		restart_layer();
	endtask

	// Waits until every item is taken and every sum has come, then lets the block settle.
	task automatic wait_idle();
		while (pending_items.size() != 0 || in_ch.valid || expected_sums.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// One setting of the layer: full parameter load, whole rows (with loads mixed in
	// unless extreme), and now and then a trailing partial row the next register write abandons.
	task automatic run_layer(input int ni_raw, input int nn_raw, input int rows,
			input bit extreme);
		int ni;
		int nn;
		write_reg(CFG_NUM_INPUTS, CFG_DATA_W'(ni_raw));
		write_reg(CFG_NUM_NODES, CFG_DATA_W'(nn_raw));
		ni = eff_inputs();
		nn = eff_nodes();
		for (int i = 0; i < nn * (ni + 1); i++)
			queue_item(FUNC_LOAD, extreme ? 16'h8000 : pick_value());
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < ni; c++) begin
				if (!extreme && $urandom_range(0, 9) == 0) queue_item(FUNC_LOAD, pick_value());
				queue_item(FUNC_SAMPLE, (extreme && r == 0) ? 16'h8000 : pick_value());
			end
		end
		if (!extreme && $urandom_range(0, 2) == 0) begin
			for (int c = 0; c < $urandom_range(0, ni - 1); c++)
				queue_item(FUNC_SAMPLE, pick_value());
			for (int i = 0; i < $urandom_range(0, 3); i++)
				queue_item(FUNC_LOAD, pick_value());
		end
		wait_idle();
	endtask

	// Driver: takes the next pending item when the channel is free, in bursts with gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.func  <= FUNC_LOAD;
			in_ch.value <= '0;
			burst_left  = 0;
			gap_left    = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) layer_step(in_ch.func, in_ch.value);
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					in_ch.valid <= 1'b0;
					gap_left--;
				end else if (pending_items.size() != 0) begin
					layer_item_t it;
					it = pending_items.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.func  <= it.func;
					in_ch.value <= it.value;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 3) == 0) ?
							$urandom_range(20, 80) : $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each sum taken against the oldest expectation and sets the stall pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_mode   = 0;
			stall_left   = 0;
			stall_tick   = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_sums.size() == 0) begin
					note_failure($sformatf("Unexpected sum: node %0d sum %0d last %0b",
						out_ch.node_index, out_ch.sum, out_ch.last));
				end else begin
					node_sum_t ex;
					ex = expected_sums.pop_front();
					if (out_ch.node_index !== ex.node_index || out_ch.sum !== ex.sum ||
					    out_ch.last !== ex.last)
						note_failure($sformatf(
							"Mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
							ex.node_index, $signed(ex.sum), ex.last,
							out_ch.node_index, out_ch.sum, out_ch.last));
				end
			end
			if (stall_left <= 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(50, 300);
			end
			stall_left--;
			stall_tick++;
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= $urandom_range(0, 1);
				2: out_ch.ready <= ($urandom_range(0, 4) == 0);
				default: out_ch.ready <= ((stall_tick % 7) < 4);
			endcase
		end
	end

	// Stimulus and end of run.
	initial begin
		int ni_raw;
		int nn_raw;
		int random_start;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_NUM_INPUTS;
		cfg_data     = '0;
		in_ch.valid  = 1'b0;
		in_ch.func   = FUNC_LOAD;
		in_ch.value  = '0;
		out_ch.ready = 1'b0;
		failure_count = 0;
		items_queued  = 0;
		reg_inputs    = NUM_INPUTS_W'(1);
		reg_nodes     = NUM_NODES_W'(1);
		restart_layer();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset sizes of one input and one node.
		queue_item(FUNC_LOAD, 16'h8000);
		queue_item(FUNC_LOAD, 16'h8000);
		queue_item(FUNC_SAMPLE, 16'h8000);
		queue_item(FUNC_SAMPLE, 16'h7FFF);
		queue_item(FUNC_SAMPLE, 16'h0000);
		queue_item(FUNC_SAMPLE, 16'hFFFF);
		// Loads wrap back to the bias after the last weight.
		queue_item(FUNC_LOAD, 16'h7FFF);
		queue_item(FUNC_LOAD, 16'h7FFF);
		queue_item(FUNC_SAMPLE, 16'h7FFF);
		queue_item(FUNC_SAMPLE, 16'h8000);
		queue_item(FUNC_LOAD, 16'h1234);
		queue_item(FUNC_LOAD, 16'hEDCB);
		queue_item(FUNC_LOAD, 16'hFFFF);
		queue_item(FUNC_SAMPLE, 16'h5A5A);
		queue_item(FUNC_SAMPLE, 16'hA5A5);
		wait_idle();

		// Extreme settings, including out-of-range register values.
		run_layer(0, 0, 3, 1'b0);
		run_layer(127, 1, 1, 1'b1);
		run_layer(1, 31, 2, 1'b0);
		run_layer(3, 2, 3, 1'b0);

		// Random settings, small layers.
		random_start = items_queued;
		while (items_queued - random_start < 60) begin
			case ($urandom_range(0, 7))
				0: ni_raw = 0;
				1: ni_raw = $urandom_range(1, 2);
				default: ni_raw = $urandom_range(1, 6);
			endcase
			if (ni_raw <= 2) begin
				case ($urandom_range(0, 5))
					0: nn_raw = $urandom_range(17, 31);
					1: nn_raw = 0;
					2: nn_raw = 16;
					default: nn_raw = $urandom_range(1, 4);
				endcase
			end else begin
				nn_raw = $urandom_range(0, 4);
			end
			run_layer(ni_raw, nn_raw, $urandom_range(1, 3), 1'b0);
		end

		wait_idle();
		if (expected_sums.size() != 0)
			note_failure("Sums still expected at the end of the run");
		if (failure_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
